>>> sv/stack_machine_core_unit_assert.svh
// Assertion macros for the stack machine core unit.
`ifndef STACK_MACHINE_CORE_UNIT_ASSERT_SVH
`define STACK_MACHINE_CORE_UNIT_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define SMC_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define SMC_ASSERT_NXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);
`endif

>>> sv/smc_pkg.sv
// ----------------------------------------------------------------------------
// smc_pkg
// Shared types and constants of the stack machine core.
// ----------------------------------------------------------------------------
`default_nettype none
package smc_pkg;
  localparam int unsigned PROGRAM_WORDS = 1024;
  localparam int unsigned STACK_DEPTH   = 32;
  localparam int unsigned PA_W = $clog2(PROGRAM_WORDS);
  localparam int unsigned SA_W = $clog2(STACK_DEPTH);
  localparam int unsigned SC_W = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0, MODE_STEP = 2'd1, MODE_RESTART = 2'd2, MODE_NONE = 2'd3
  } mode_t;

  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_HALT  = 2'd1;
  localparam logic [1:0] ST_BREAK = 2'd2;

  localparam logic [31:0] OP_BREAK = 32'd0;
  localparam logic [31:0] OP_NOP   = 32'd1;
  localparam logic [31:0] OP_HALT  = 32'd2;
  localparam logic [31:0] OP_PUSH  = 32'd3;
  localparam logic [31:0] OP_PRINT = 32'd4;
  localparam logic [31:0] OP_JNE   = 32'd5;
  localparam logic [31:0] OP_SWAP  = 32'd6;
  localparam logic [31:0] OP_DUP   = 32'd7;
  localparam logic [31:0] OP_JE    = 32'd8;
  localparam logic [31:0] OP_INC   = 32'd9;
  localparam logic [31:0] OP_ADD   = 32'd10;
  localparam logic [31:0] OP_SUB   = 32'd11;
  localparam logic [31:0] OP_MUL   = 32'd12;
  localparam logic [31:0] OP_RAND  = 32'd13;
  localparam logic [31:0] OP_DEC   = 32'd14;
  localparam logic [31:0] OP_DROP  = 32'd15;
  localparam logic [31:0] OP_OVER  = 32'd16;
  localparam logic [31:0] OP_MOD   = 32'd17;
  localparam logic [31:0] OP_JUMP  = 32'd18;
  localparam logic [31:0] OP_AND   = 32'd19;
  localparam logic [31:0] OP_OR    = 32'd20;
  localparam logic [31:0] OP_XOR   = 32'd21;
  localparam logic [31:0] OP_SHL   = 32'd22;
  localparam logic [31:0] OP_SHR   = 32'd23;
  localparam logic [31:0] OP_SQRT  = 32'd24;
  localparam logic [31:0] OP_ROT   = 32'd25;
  localparam logic [31:0] OP_PICK  = 32'd26;

  // Operations of the shared iterative unit.
  typedef enum logic [1:0] { IT_MOD = 2'd0, IT_SQRT = 2'd1 } it_op_t;

  typedef struct packed {
    logic        start;
    it_op_t      op;
    logic [31:0] a;
    logic [31:0] b;
  } it_req_t;

  typedef struct packed {
    logic        done;
    logic        busy;
    logic [31:0] res;
  } it_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_FETCH2, S_DECODE, S_POP, S_POPW, S_EXEC,
    S_ITER, S_PICKRD, S_PICKW, S_PUSH, S_DONE, S_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]  run_state;
    logic [31:0] program_counter;
    logic [5:0]  stack_depth;
    logic [31:0] top_value;
    logic        print_valid;
    logic signed [31:0] print_value;
    logic [31:0] steps_done;
  } result_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [9:0]  load_address;
    logic [31:0] load_word;
    logic [31:0] random_value;
  } item_t;
endpackage
`default_nettype wire

>>> sv/smc_if.sv
// ----------------------------------------------------------------------------
// smc_if
// Valid/ready channel carrying one packed payload.
// ----------------------------------------------------------------------------
`default_nettype none
interface smc_in_if;
  logic valid;
  logic ready;
  smc_pkg::item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface smc_out_if;
  logic valid;
  logic ready;
  smc_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/smc_iter_unit.sv
// ----------------------------------------------------------------------------
// smc_iter_unit
// Shared radix-2 unit for unsigned modulo and integer square root.
// ----------------------------------------------------------------------------
`default_nettype none
module smc_iter_unit (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire smc_pkg::it_req_t req,
  output smc_pkg::it_rsp_t     rsp
);
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  smc_pkg::it_op_t op_r, op_nxt;
  logic [31:0] x_r, x_nxt, d_r, d_nxt, rem_r, rem_nxt, root_r, root_nxt;
  logic [32:0] trial_rem;
  logic [33:0] sq_rem, sq_try;

  always_comb begin
    cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0; op_nxt = op_r;
    x_nxt = x_r; d_nxt = d_r; rem_nxt = rem_r; root_nxt = root_r;
    trial_rem = {rem_r, x_r[31]};
    // Square root: two bits of the radicand enter the partial remainder each step.
    sq_rem = {rem_r, x_r[31:30]};
    sq_try = {root_r, 2'b01};
    if (req.start) begin
      busy_nxt = 1'b1; op_nxt = req.op; x_nxt = req.a; d_nxt = req.b;
      rem_nxt = '0; root_nxt = '0;
      cnt_nxt = (req.op == smc_pkg::IT_MOD) ? 6'd32 : 6'd16;
    end else if (busy_r) begin
      unique case (op_r)
        smc_pkg::IT_MOD: begin
          x_nxt = {x_r[30:0], 1'b0};
          if (trial_rem >= {1'b0, d_r}) rem_nxt = 32'(trial_rem - {1'b0, d_r});
          else rem_nxt = trial_rem[31:0];
        end
        default: begin
          x_nxt = {x_r[29:0], 2'b00};
          if (sq_rem >= sq_try) begin
            rem_nxt = 32'(sq_rem - sq_try);
            root_nxt = {root_r[30:0], 1'b1};
          end else begin
            rem_nxt = sq_rem[31:0];
            root_nxt = {root_r[30:0], 1'b0};
          end
        end
      endcase
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    op_r <= op_nxt; x_r <= x_nxt; d_r <= d_nxt; rem_r <= rem_nxt; root_r <= root_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.busy = busy_r;
  assign rsp.res  = (op_r == smc_pkg::IT_MOD) ? rem_r : root_r;
endmodule
`default_nettype wire

>>> sv/stack_machine_core_unit.sv
// ----------------------------------------------------------------------------
// stack_machine_core_unit
// Stack machine interpreter: program store, data stack and step sequencer.
// ----------------------------------------------------------------------------
// Channel | Dir | Contents
// in      | in  | mode, load_address, load_word, random_value
// out     | out | run_state, program_counter, stack_depth, top_value, print, steps_done
// cfg     | in  | step_limit write
//
// A load or restart goes from IDLE to DONE and OUT; an instruction's duration
// grows with its stack pops and pushes; square root and modulo wait while the
// shared iterative unit runs 16 or 32 steps (one bit each).
// Reset is synchronous and clears control state only; memories hold no reset.
// The input is not ready while an item is in progress; a finished result waits
// in the output register, and only the next result stalls until it is taken.
`default_nettype none
`include "stack_machine_core_unit_assert.svh"
module stack_machine_core_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  smc_in_if.sink          in_ch,
  smc_out_if.source       out_ch,
  input  wire logic       cfg_we,
  input  wire logic [31:0] cfg_wdata
);
  localparam int unsigned PA_W = smc_pkg::PA_W;
  localparam int unsigned SA_W = smc_pkg::SA_W;
  localparam int unsigned SC_W = smc_pkg::SC_W;

  logic [31:0] prog_mem [smc_pkg::PROGRAM_WORDS];
  logic [31:0] stk_mem  [smc_pkg::STACK_DEPTH];

  smc_pkg::state_t state_r, state_nxt;
  smc_pkg::item_t  item_r, item_nxt;
  logic [31:0] limit_r, pc_r, pc_nxt, steps_r, steps_nxt, op_r, op_nxt, imm_r, imm_nxt;
  logic [31:0] top_r, top_nxt;
  logic [SC_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]  st_r, st_nxt;
  logic [1:0]  len_r, len_nxt;
  logic [1:0]  npop_r, npop_nxt, pidx_r, pidx_nxt;
  logic [31:0] pa_r, pa_nxt, pb_r, pb_nxt, pc3_r, pc3_nxt;
  logic [31:0] q0_r, q0_nxt, q1_r, q1_nxt, q2_r, q2_nxt;
  logic [1:0]  nq_r, nq_nxt, qi_r, qi_nxt;
  logic        pv_r, pv_nxt;
  logic [31:0] pval_r, pval_nxt;
  smc_pkg::result_t res_r, res_nxt;
  logic        ovalid_r, ovalid_nxt;

  logic        pm_we;  logic [PA_W-1:0] pm_wa, pm_ra; logic [31:0] pm_rd_r;
  logic        sm_we;  logic [SA_W-1:0] sm_wa, sm_ra; logic [31:0] sm_wd, sm_rd_r;
  smc_pkg::it_req_t ireq;
  smc_pkg::it_rsp_t irsp;
  logic [31:0] a_v, b_v;

  smc_iter_unit u_iter (.clk(clk), .rst_n(rst_n), .req(ireq), .rsp(irsp));

  always_ff @(posedge clk) begin
    if (pm_we) prog_mem[pm_wa] <= item_r.load_word;
    pm_rd_r <= prog_mem[pm_ra];
    if (sm_we) stk_mem[sm_wa] <= sm_wd;
    sm_rd_r <= stk_mem[sm_ra];
  end

  assign a_v = pa_r;
  assign b_v = pb_r;

  always_comb begin
    state_nxt = state_r; item_nxt = item_r; pc_nxt = pc_r; steps_nxt = steps_r;
    op_nxt = op_r; imm_nxt = imm_r; cnt_nxt = cnt_r; st_nxt = st_r; len_nxt = len_r;
    npop_nxt = npop_r; pidx_nxt = pidx_r; pa_nxt = pa_r; pb_nxt = pb_r; pc3_nxt = pc3_r;
    q0_nxt = q0_r; q1_nxt = q1_r; q2_nxt = q2_r; nq_nxt = nq_r; qi_nxt = qi_r;
    pv_nxt = pv_r; pval_nxt = pval_r; top_nxt = top_r;
    res_nxt = res_r; ovalid_nxt = ovalid_r;
    pm_we = 1'b0; pm_wa = item_r.load_address[PA_W-1:0]; pm_ra = pc_r[PA_W-1:0];
    sm_we = 1'b0; sm_wa = '0; sm_wd = '0; sm_ra = '0;
    ireq = '0;
    in_ch.ready = (state_r == smc_pkg::S_IDLE);
    if (out_ch.ready) ovalid_nxt = 1'b0;

    unique case (state_r)
      smc_pkg::S_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          item_nxt = in_ch.data; pv_nxt = 1'b0; pval_nxt = '0;
          unique case (smc_pkg::mode_t'(in_ch.data.mode))
            smc_pkg::MODE_LOAD: state_nxt = smc_pkg::S_DONE;
            smc_pkg::MODE_STEP: begin
              if (st_r != smc_pkg::ST_RUN || steps_r >= limit_r) state_nxt = smc_pkg::S_DONE;
              else if (pc_r >= 32'(smc_pkg::PROGRAM_WORDS)) begin
                st_nxt = smc_pkg::ST_BREAK; state_nxt = smc_pkg::S_DONE;
              end else state_nxt = smc_pkg::S_FETCH;
            end
            smc_pkg::MODE_RESTART: begin
              pc_nxt = '0; cnt_nxt = '0; st_nxt = smc_pkg::ST_RUN; steps_nxt = '0;
              state_nxt = smc_pkg::S_DONE;
            end
            default: state_nxt = smc_pkg::S_DONE;
          endcase
        end
      end
      smc_pkg::S_FETCH: begin
        // The opcode word is on the read port; request the immediate word.
        op_nxt = pm_rd_r; len_nxt = 2'd1;
        pm_ra = PA_W'(pc_r + 32'd1);
        state_nxt = smc_pkg::S_FETCH2;
      end
      smc_pkg::S_FETCH2: begin
        imm_nxt = pm_rd_r;
        state_nxt = smc_pkg::S_DECODE;
      end
      smc_pkg::S_DECODE: begin
        if (op_r == smc_pkg::OP_PUSH || op_r == smc_pkg::OP_JNE ||
            op_r == smc_pkg::OP_JE || op_r == smc_pkg::OP_JUMP) begin
          if (pc_r + 32'd1 < 32'(smc_pkg::PROGRAM_WORDS)) len_nxt = 2'd2;
          else op_nxt = smc_pkg::OP_BREAK;
        end
        priority case (op_r)
          smc_pkg::OP_PRINT, smc_pkg::OP_JNE, smc_pkg::OP_JE, smc_pkg::OP_DUP,
          smc_pkg::OP_INC, smc_pkg::OP_DEC, smc_pkg::OP_SQRT, smc_pkg::OP_DROP,
          smc_pkg::OP_PICK: npop_nxt = 2'd1;
          smc_pkg::OP_ROT: npop_nxt = 2'd3;
          smc_pkg::OP_SWAP, smc_pkg::OP_OVER, smc_pkg::OP_ADD, smc_pkg::OP_SUB,
          smc_pkg::OP_MUL, smc_pkg::OP_MOD, smc_pkg::OP_AND, smc_pkg::OP_OR,
          smc_pkg::OP_XOR, smc_pkg::OP_SHL, smc_pkg::OP_SHR: npop_nxt = 2'd2;
          default: npop_nxt = 2'd0;
        endcase
        if (len_nxt == 2'd1 && (op_r == smc_pkg::OP_JNE || op_r == smc_pkg::OP_JE))
          npop_nxt = 2'd0;
        pidx_nxt = '0;
        state_nxt = smc_pkg::S_POP;
      end
      smc_pkg::S_POP: begin
        if (pidx_r == npop_r) state_nxt = smc_pkg::S_EXEC;
        else if (cnt_r == '0) begin
          st_nxt = smc_pkg::ST_BREAK; pidx_nxt = pidx_r + 2'd1;
          if (pidx_r == 2'd0) pa_nxt = '0;
          else if (pidx_r == 2'd1) pb_nxt = '0;
          else pc3_nxt = '0;
        end else begin
          sm_ra = SA_W'(cnt_r - SC_W'(1));
          cnt_nxt = cnt_r - SC_W'(1);
          state_nxt = smc_pkg::S_POPW;
        end
      end
      smc_pkg::S_POPW: begin
        if (pidx_r == 2'd0) pa_nxt = sm_rd_r;
        else if (pidx_r == 2'd1) pb_nxt = sm_rd_r;
        else pc3_nxt = sm_rd_r;
        pidx_nxt = pidx_r + 2'd1;
        state_nxt = smc_pkg::S_POP;
      end
      smc_pkg::S_EXEC: begin
        nq_nxt = '0; qi_nxt = '0;
        state_nxt = smc_pkg::S_PUSH;
        if (op_r == smc_pkg::OP_HALT) st_nxt = smc_pkg::ST_HALT;
        else if (op_r == smc_pkg::OP_PUSH) begin q0_nxt = imm_r; nq_nxt = 2'd1; end
        else if (op_r == smc_pkg::OP_RAND) begin q0_nxt = item_r.random_value; nq_nxt = 2'd1; end
        else if (op_r == smc_pkg::OP_JUMP) pc_nxt = pc_r + imm_r;
        else if (op_r == smc_pkg::OP_NOP || op_r == smc_pkg::OP_DROP) nq_nxt = '0;
        else if (op_r > smc_pkg::OP_PICK || op_r == smc_pkg::OP_BREAK) st_nxt = smc_pkg::ST_BREAK;
        else if (st_r == smc_pkg::ST_RUN) begin
          priority case (op_r)
            smc_pkg::OP_PRINT: begin pv_nxt = 1'b1; pval_nxt = a_v; end
            smc_pkg::OP_JNE: if (a_v != '0) pc_nxt = pc_r + imm_r;
            smc_pkg::OP_JE:  if (a_v == '0) pc_nxt = pc_r + imm_r;
            smc_pkg::OP_SWAP: begin q0_nxt = a_v; q1_nxt = b_v; nq_nxt = 2'd2; end
            smc_pkg::OP_OVER: begin q0_nxt = b_v; q1_nxt = a_v; q2_nxt = b_v; nq_nxt = 2'd3; end
            smc_pkg::OP_DUP: begin q0_nxt = a_v; q1_nxt = a_v; nq_nxt = 2'd2; end
            smc_pkg::OP_INC: begin q0_nxt = a_v + 32'd1; nq_nxt = 2'd1; end
            smc_pkg::OP_DEC: begin q0_nxt = a_v - 32'd1; nq_nxt = 2'd1; end
            smc_pkg::OP_ADD: begin q0_nxt = a_v + b_v; nq_nxt = 2'd1; end
            smc_pkg::OP_SUB: begin q0_nxt = a_v - b_v; nq_nxt = 2'd1; end
            smc_pkg::OP_MUL: begin q0_nxt = a_v * b_v; nq_nxt = 2'd1; end
            smc_pkg::OP_AND: begin q0_nxt = a_v & b_v; nq_nxt = 2'd1; end
            smc_pkg::OP_OR:  begin q0_nxt = a_v | b_v; nq_nxt = 2'd1; end
            smc_pkg::OP_XOR: begin q0_nxt = a_v ^ b_v; nq_nxt = 2'd1; end
            smc_pkg::OP_SHL: begin
              q0_nxt = (b_v >= 32'd32) ? '0 : (a_v << b_v[4:0]); nq_nxt = 2'd1;
            end
            smc_pkg::OP_SHR: begin
              q0_nxt = (b_v >= 32'd32) ? '0 : (a_v >> b_v[4:0]); nq_nxt = 2'd1;
            end
            smc_pkg::OP_ROT: begin q0_nxt = a_v; q1_nxt = pc3_r; q2_nxt = b_v; nq_nxt = 2'd3; end
            smc_pkg::OP_MOD: begin
              if (b_v == '0) st_nxt = smc_pkg::ST_BREAK;
              else begin
                ireq.start = 1'b1; ireq.op = smc_pkg::IT_MOD; ireq.a = a_v; ireq.b = b_v;
                state_nxt = smc_pkg::S_ITER;
              end
            end
            smc_pkg::OP_SQRT: begin
              ireq.start = 1'b1; ireq.op = smc_pkg::IT_SQRT; ireq.a = a_v;
              state_nxt = smc_pkg::S_ITER;
            end
            smc_pkg::OP_PICK: begin
              if (a_v[31] || ({1'b0, a_v} + 33'd2 > 33'(cnt_r))) begin
                st_nxt = smc_pkg::ST_BREAK; q0_nxt = '0; nq_nxt = 2'd1;
              end else begin
                sm_ra = SA_W'(32'(cnt_r) - 32'd1 - a_v);
                state_nxt = smc_pkg::S_PICKRD;
              end
            end
            default: nq_nxt = '0;
          endcase
        end
      end
      smc_pkg::S_ITER: begin
        if (irsp.done) begin
          q0_nxt = irsp.res; nq_nxt = 2'd1; state_nxt = smc_pkg::S_PUSH;
        end
      end
      smc_pkg::S_PICKRD: begin
        sm_ra = SA_W'(32'(cnt_r) - 32'd1 - a_v);
        state_nxt = smc_pkg::S_PICKW;
      end
      smc_pkg::S_PICKW: begin
        q0_nxt = sm_rd_r; nq_nxt = 2'd1; state_nxt = smc_pkg::S_PUSH;
      end
      smc_pkg::S_PUSH: begin
        if (qi_r == nq_r) begin
          pc_nxt = pc_r + 32'(len_r); steps_nxt = steps_r + 32'd1;
          state_nxt = smc_pkg::S_DONE;
        end else begin
          qi_nxt = qi_r + 2'd1;
          if (cnt_r >= SC_W'(smc_pkg::STACK_DEPTH)) st_nxt = smc_pkg::ST_BREAK;
          else begin
            sm_we = 1'b1; sm_wa = SA_W'(cnt_r);
            sm_wd = (qi_r == 2'd0) ? q0_r : ((qi_r == 2'd1) ? q1_r : q2_r);
            cnt_nxt = cnt_r + SC_W'(1);
          end
        end
      end
      smc_pkg::S_DONE: begin
        if (item_r.mode == smc_pkg::MODE_LOAD &&
            32'(item_r.load_address) < 32'(smc_pkg::PROGRAM_WORDS)) pm_we = 1'b1;
        sm_ra = SA_W'(cnt_r - SC_W'(1));
        state_nxt = smc_pkg::S_OUT;
      end
      smc_pkg::S_OUT: begin
        // Hold the top entry on the read port until the output register is free.
        sm_ra = SA_W'(cnt_r - SC_W'(1));
        if (!ovalid_r || out_ch.ready) begin
          res_nxt.run_state = st_r;
          res_nxt.program_counter = pc_r;
          res_nxt.stack_depth = 6'(cnt_r);
          res_nxt.top_value = (cnt_r != '0) ? sm_rd_r : '0;
          res_nxt.print_valid = pv_r;
          res_nxt.print_value = pval_r;
          res_nxt.steps_done = steps_r;
          ovalid_nxt = 1'b1;
          top_nxt = res_nxt.top_value;
          state_nxt = smc_pkg::S_IDLE;
        end
      end
      default: state_nxt = smc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smc_pkg::S_IDLE; ovalid_r <= 1'b0; limit_r <= '1;
      pc_r <= '0; cnt_r <= '0; st_r <= smc_pkg::ST_RUN; steps_r <= '0;
    end else begin
      state_r <= state_nxt; ovalid_r <= ovalid_nxt;
      if (cfg_we) limit_r <= cfg_wdata;
      pc_r <= pc_nxt; cnt_r <= cnt_nxt; st_r <= st_nxt; steps_r <= steps_nxt;
    end
    item_r <= item_nxt; op_r <= op_nxt; imm_r <= imm_nxt; len_r <= len_nxt;
    npop_r <= npop_nxt; pidx_r <= pidx_nxt; pa_r <= pa_nxt; pb_r <= pb_nxt;
    pc3_r <= pc3_nxt; q0_r <= q0_nxt; q1_r <= q1_nxt; q2_r <= q2_nxt;
    nq_r <= nq_nxt; qi_r <= qi_nxt; pv_r <= pv_nxt; pval_r <= pval_nxt;
    res_r <= res_nxt; top_r <= top_nxt;
  end

  assign out_ch.valid = ovalid_r;
  assign out_ch.data  = res_r;

  `SMC_ASSERT_IMP(a_depth_max, clk, rst_n, 1'b1, cnt_r <= SC_W'(smc_pkg::STACK_DEPTH), "stack count beyond depth")
  `SMC_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_r != smc_pkg::S_IDLE, !in_ch.ready, "ready while busy")
  `SMC_ASSERT_NXT(a_iter_wait, clk, rst_n, ireq.start, state_r == smc_pkg::S_ITER, "iterative unit started outside wait")
  `SMC_ASSERT_IMP(a_top_match, clk, rst_n, ovalid_r, res_r.top_value == top_r, "top value mismatch")
endmodule
`default_nettype wire
